### hw/rtl/cia402_drive_sequencer_assert.svh
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CIA402_DRIVE_SEQUENCER_ASSERT_SVH
`define CIA402_DRIVE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside of reset.
`define CDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define CDS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CDS_ASSERT(lbl, prop, msg)
`define CDS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer package
// Types, command and result codes, and drive object constants shared by
// the sequencer modules and its channel interfaces.
// ----------------------------------------------------------------------------
package cds_pkg;

    // Commands carried by the mode field of an input word.
    typedef enum logic [2:0] {
        CMD_ENABLE     = 3'd0,
        CMD_HOME       = 3'd1,
        CMD_SET_CSP    = 3'd2,
        CMD_SET_CSV    = 3'd3,
        CMD_SET_CST    = 3'd4,
        CMD_SET_VEL    = 3'd5,
        CMD_SET_TORQUE = 3'd6
    } cmd_t;

    // Drive phase kept by the sequencer.
    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_ENABLED = 3'd1,
        PH_HOMED   = 3'd2,
        PH_CSP     = 3'd3,
        PH_CSV     = 3'd4,
        PH_CST     = 3'd5
    } phase_t;

    // Result codes returned with every word.
    typedef enum logic [3:0] {
        RC_OK               = 4'd0,
        RC_BUSY             = 4'd1,
        RC_NOT_ENABLED      = 4'd2,
        RC_HOME_NOT_STARTED = 4'd3,
        RC_HOME_RUNNING     = 4'd4,
        RC_HOME_ERROR       = 4'd5,
        RC_MODE_SET         = 4'd6,
        RC_MODE_SETTING     = 4'd7,
        RC_WRONG_MODE       = 4'd8,
        RC_ENABLE_FAILED    = 4'd9,
        RC_INVALID          = 4'd10
    } rc_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SETTLE_CYCLES     = 2'd0;
    localparam logic [1:0] CFG_FAULT_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_HOME_PULSE_CYCLES = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  SETTLE_CYCLES_RST     = 8'd50;
    localparam logic [15:0] FAULT_RETRY_LIMIT_RST = 16'd1000;
    localparam logic [6:0]  HOME_PULSE_CYCLES_RST = 7'd10;

    // Status word masks and power states.
    localparam logic [15:0] SW_STATE_MASK     = 16'h006f;
    localparam logic [15:0] SW_HOME_MASK      = 16'h3400;
    localparam logic [15:0] SW_SWITCH_DIS_A   = 16'h0040;
    localparam logic [15:0] SW_SWITCH_DIS_B   = 16'h0060;
    localparam logic [15:0] SW_READY          = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON    = 16'h0023;
    localparam logic [15:0] SW_OP_ENABLED     = 16'h0027;
    localparam logic [15:0] SW_HOME_IDLE      = 16'h0400;
    localparam logic [15:0] SW_HOME_ACTIVE    = 16'h0000;
    localparam logic [15:0] SW_HOME_ERR_A     = 16'h2000;
    localparam logic [15:0] SW_HOME_ERR_B     = 16'h2400;
    localparam logic [15:0] SW_HOME_DONE      = 16'h1400;

    // Control word commands.
    localparam logic [15:0] CW_SHUTDOWN       = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON      = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP      = 16'h000f;
    localparam logic [15:0] CW_FAULT_RESET    = 16'h0080;
    localparam logic [15:0] CW_HOME_START     = 16'h001f;
    localparam logic [15:0] CW_HALT           = 16'h0100;

    // Operating mode codes.
    localparam logic [7:0] OPM_HOMING = 8'h06;
    localparam logic [7:0] OPM_CSP    = 8'h08;
    localparam logic [7:0] OPM_CSV    = 8'h09;
    localparam logic [7:0] OPM_CST    = 8'h0a;

    localparam logic [7:0] HOME_COUNT_MAX = 8'hff;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic [7:0]  settle_cycles;
        logic [15:0] fault_retry_limit;
        logic [6:0]  home_pulse_cycles;
    } cfg_t;

    // Sequencer state.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  settle_count;
        logic [15:0] fault_count;
        logic [7:0]  home_count;
    } state_t;

    // One input word.
    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        drive_status;
        logic signed [7:0]  shown_mode;
        logic signed [31:0] act_position;
        logic signed [31:0] velocity_value;
        logic signed [15:0] torque_value;
    } in_item_t;

    // One result word.
    typedef struct packed {
        logic [15:0]        ctrl_word;
        logic               ctrl_word_write;
        logic signed [7:0]  op_mode_value;
        logic               op_mode_write;
        logic signed [31:0] target_position;
        logic               target_position_write;
        logic signed [31:0] target_velocity;
        logic               target_velocity_write;
        logic signed [15:0] target_torque;
        logic               target_torque_write;
        logic [3:0]         result_code;
        logic [2:0]         phase_now;
    } out_item_t;

endpackage

### hw/rtl/cds_if.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface cds_in_if;
    import cds_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cds_out_if;
    import cds_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/cds_cfg_regs.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer configuration registers
// Holds settle count, fault retry limit and homing pulse length.
// ----------------------------------------------------------------------------
module cds_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    output cds_pkg::cfg_t         cfg
);
    import cds_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_cycles     <= SETTLE_CYCLES_RST;
            cfg_reg.fault_retry_limit <= FAULT_RETRY_LIMIT_RST;
            cfg_reg.home_pulse_cycles <= HOME_PULSE_CYCLES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SETTLE_CYCLES:     cfg_reg.settle_cycles     <= cfg_wdata[7:0];
                CFG_FAULT_RETRY_LIMIT: cfg_reg.fault_retry_limit <= cfg_wdata[15:0];
                CFG_HOME_PULSE_CYCLES: cfg_reg.home_pulse_cycles <= cfg_wdata[6:0];
                default:               ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/cds_step.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer step logic
// Computes the result word and the next state for one command word.
// ----------------------------------------------------------------------------
module cds_step (
    input  cds_pkg::cfg_t     cfg,
    input  cds_pkg::state_t   st,
    input  cds_pkg::in_item_t item,
    output cds_pkg::state_t   st_next,
    output cds_pkg::out_item_t res
);
    import cds_pkg::*;

    logic [15:0] sw_state;
    logic [15:0] sw_home;
    logic [7:0]  md;
    logic [7:0]  hc_inc;
    logic [7:0]  pulse_len;
    logic [7:0]  pulse_end;
    rc_t         rc;

    assign sw_state  = item.drive_status & SW_STATE_MASK;
    assign sw_home   = item.drive_status & SW_HOME_MASK;
    assign md        = item.shown_mode;
    assign pulse_len = {1'b0, cfg.home_pulse_cycles};
    assign pulse_end = {cfg.home_pulse_cycles, 1'b0};
    assign hc_inc    = (st.home_count < HOME_COUNT_MAX) ? st.home_count + 8'd1
                                                        : st.home_count;

    always_comb
    begin
        st_next = st;
        res     = '0;
        rc      = RC_INVALID;

        case (item.mode)
            // Walk the drive through the power state machine.
            CMD_ENABLE:
            begin
                if (st.phase == PH_ENABLED)
                begin
                    rc = RC_OK;
                end
                else
                begin
                    rc = RC_BUSY;
                    // Hold the targets until the drive is operating.
                    if (sw_state != SW_OP_ENABLED)
                    begin
                        res.target_position       = item.act_position;
                        res.target_position_write = 1'b1;
                        res.target_velocity_write = 1'b1;
                        res.target_torque_write   = 1'b1;
                    end
                    if (md != OPM_CST)
                    begin
                        res.op_mode_value = OPM_CST;
                        res.op_mode_write = 1'b1;
                    end
                    else if (sw_state inside {SW_SWITCH_DIS_A, SW_SWITCH_DIS_B})
                    begin
                        res.ctrl_word       = CW_SHUTDOWN;
                        res.ctrl_word_write = 1'b1;
                    end
                    else if (sw_state == SW_READY)
                    begin
                        res.ctrl_word       = CW_SWITCH_ON;
                        res.ctrl_word_write = 1'b1;
                    end
                    else if (sw_state == SW_SWITCHED_ON)
                    begin
                        res.ctrl_word       = CW_ENABLE_OP;
                        res.ctrl_word_write = 1'b1;
                    end
                    else if (sw_state == SW_OP_ENABLED)
                    begin
                        st_next.settle_count = st.settle_count + 8'd1;
                        if (st_next.settle_count >= cfg.settle_cycles)
                        begin
                            st_next.settle_count = '0;
                            st_next.phase        = PH_ENABLED;
                        end
                    end
                    else
                    begin
                        // Fault or unknown state: issue a fault reset.
                        res.ctrl_word       = CW_FAULT_RESET;
                        res.ctrl_word_write = 1'b1;
                        if (st.fault_count >= cfg.fault_retry_limit)
                        begin
                            st_next.fault_count = '0;
                            st_next.phase       = PH_INIT;
                            rc                  = RC_ENABLE_FAILED;
                        end
                        else
                        begin
                            st_next.fault_count = st.fault_count + 16'd1;
                        end
                    end
                end
            end

            // Homing: select homing mode, then pulse the start bit.
            CMD_HOME:
            begin
                if (st.phase == PH_HOMED)
                begin
                    rc = RC_OK;
                end
                else if (st.phase != PH_ENABLED)
                begin
                    rc = RC_NOT_ENABLED;
                end
                else if (md != OPM_HOMING)
                begin
                    res.op_mode_value = OPM_HOMING;
                    res.op_mode_write = 1'b1;
                    rc                = RC_BUSY;
                end
                else if (sw_home == SW_HOME_IDLE)
                begin
                    rc = RC_HOME_NOT_STARTED;
                    st_next.home_count = hc_inc;
                    if (hc_inc < pulse_len)
                    begin
                        res.ctrl_word       = CW_HOME_START;
                        res.ctrl_word_write = 1'b1;
                    end
                    else if (hc_inc < pulse_end)
                    begin
                        res.ctrl_word       = CW_ENABLE_OP;
                        res.ctrl_word_write = 1'b1;
                    end
                    else
                    begin
                        st_next.home_count = '0;
                    end
                end
                else
                begin
                    st_next.home_count = '0;
                    if (sw_home == SW_HOME_ACTIVE)
                    begin
                        res.ctrl_word       = CW_HOME_START;
                        res.ctrl_word_write = 1'b1;
                        rc                  = RC_HOME_RUNNING;
                    end
                    else if (sw_home inside {SW_HOME_ERR_A, SW_HOME_ERR_B})
                    begin
                        res.ctrl_word       = CW_HALT;
                        res.ctrl_word_write = 1'b1;
                        rc                  = RC_HOME_ERROR;
                    end
                    else if (sw_home == SW_HOME_DONE)
                    begin
                        st_next.phase = PH_HOMED;
                        rc            = RC_OK;
                    end
                    else
                    begin
                        rc = RC_HOME_RUNNING;
                    end
                end
            end

            // Mode selection: seed the new target (actual position for CSP, zero otherwise), then request the mode.
            CMD_SET_CSP:
            begin
                if (st.phase == PH_CSP)
                begin
                    rc = RC_MODE_SET;
                end
                else
                begin
                    res.target_position       = item.act_position;
                    res.target_position_write = 1'b1;
                    st_next.phase             = PH_CSP;
                    if (md == OPM_CSP)
                    begin
                        rc = RC_MODE_SET;
                    end
                    else
                    begin
                        res.op_mode_value = OPM_CSP;
                        res.op_mode_write = 1'b1;
                        rc                = RC_MODE_SETTING;
                    end
                end
            end

            CMD_SET_CSV:
            begin
                if (st.phase == PH_CSV)
                begin
                    rc = RC_MODE_SET;
                end
                else
                begin
                    res.target_velocity_write = 1'b1;
                    st_next.phase             = PH_CSV;
                    if (md == OPM_CSV)
                    begin
                        rc = RC_MODE_SET;
                    end
                    else
                    begin
                        res.op_mode_value = OPM_CSV;
                        res.op_mode_write = 1'b1;
                        rc                = RC_MODE_SETTING;
                    end
                end
            end

            CMD_SET_CST:
            begin
                if (st.phase == PH_CST)
                begin
                    rc = RC_MODE_SET;
                end
                else
                begin
                    res.target_torque_write = 1'b1;
                    st_next.phase           = PH_CST;
                    if (md == OPM_CST)
                    begin
                        rc = RC_MODE_SET;
                    end
                    else
                    begin
                        res.op_mode_value = OPM_CST;
                        res.op_mode_write = 1'b1;
                        rc                = RC_MODE_SETTING;
                    end
                end
            end

            // Target setters only act in their own run mode.
            CMD_SET_VEL:
            begin
                if (st.phase != PH_CSV)
                begin
                    rc = RC_WRONG_MODE;
                end
                else
                begin
                    res.target_velocity       = item.velocity_value;
                    res.target_velocity_write = 1'b1;
                    rc                        = RC_OK;
                end
            end

            CMD_SET_TORQUE:
            begin
                if (st.phase != PH_CST)
                begin
                    rc = RC_WRONG_MODE;
                end
                else
                begin
                    res.target_torque       = item.torque_value;
                    res.target_torque_write = 1'b1;
                    rc                      = RC_OK;
                end
            end

            default:
            begin
                rc = RC_INVALID;
            end
        endcase

        res.result_code = rc;
        res.phase_now   = st_next.phase;
    end

endmodule

### hw/rtl/cia402_drive_sequencer.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer
// Master-side enable, homing and mode sequencing for one servo drive.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command word per fieldbus cycle on the cmd channel, carrying
//   the command plus the drive's latest status word, mode display and
//   actual position. Each word yields exactly one result word on rsp:
//   drive object writes with strobes, a result code and the phase.
//   The configuration port sets settle count, retry limit and homing
//   pulse length; write it only while no word is in flight.
//   An accepted word sits in the input register, and the step logic
//   loads its result into the result register once that register is
//   free or drains. Throughput is one word per cycle while rsp takes
//   each result, set by the single state update that the step logic
//   performs per word.
//   When rsp stalls, the word in the input register waits and cmd ready
//   drops once both registers are full; nothing is lost or repeated.
//   Reset clears the phase to init, all counters to zero, empties both
//   registers and restores the configuration defaults.
// ----------------------------------------------------------------------------
`include "cia402_drive_sequencer_assert.svh"

module cia402_drive_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    cds_in_if.sink      cmd,
    cds_out_if.source   rsp
);
    import cds_pkg::*;

    cfg_t      cfg;
    state_t    st_reg;
    state_t    st_next;
    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    cds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cds_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (out_item_next)
    );

    // The input word moves on when the result register is free or drains.
    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign cmd.ready = !in_vld_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg <= cmd.data;
        end
    end

    // State and result register update together, once per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '{phase: PH_INIT, default: '0};
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg      <= st_next;
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_item_reg;

    // Checks on the pipeline and the sequencer state.
    `CDS_ASSERT(a_phase_matches_rsp, !out_vld_reg || (out_item_reg.phase_now == st_reg.phase), "result phase differs from state phase")
    `CDS_ASSERT(a_enabled_settle_clear, (st_reg.phase != PH_ENABLED) || (st_reg.settle_count == 8'd0), "settle count not cleared in enabled phase")
    `CDS_ASSERT_NEXT(a_advance_fills, advance, out_vld_reg, "result register not filled after advance")
    `CDS_ASSERT_NEXT(a_stall_holds_state, !advance, $stable(st_reg), "state changed without a word")

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// CiA 402 drive sequencer testbench
// Drives command words into the sequencer and predicts each result word with
// a cycle-free model of the enable, homing and mode logic. Every result word
// is compared field by field. Stimulus is a short directed walk through the
// power state machine and homing, then random enable, homing and mode
// sequences under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cds_pkg::*;

    // Command code that the block must reject.
    localparam logic [2:0]  CMD_UNUSED = 3'd7;
    // Power state the drive shows after a fault.
    localparam logic [15:0] SW_FAULT   = 16'h0008;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    cds_in_if  cmd_bus ();
    cds_out_if rsp_bus ();

    cia402_drive_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus)
    );

    // Predicted sequencer state and its copy of the registers.
    phase_t      seq_phase   = PH_INIT;
    logic [7:0]  settle_ctr  = '0;
    logic [15:0] fault_ctr   = '0;
    logic [7:0]  home_ctr    = '0;
    logic [7:0]  cfg_settle  = SETTLE_CYCLES_RST;
    logic [15:0] cfg_retries = FAULT_RETRY_LIMIT_RST;
    logic [6:0]  cfg_pulse   = HOME_PULSE_CYCLES_RST;

    in_item_t  cmd_queue[$];
    out_item_t expected_rsp[$];
    int        n_queued    = 0;
    int        mismatches  = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    bit        cmd_taken   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Works out the result word for one command word and advances the state.
    function automatic out_item_t sequencer_response(in_item_t it);
        out_item_t   r;
        logic [15:0] st;
        logic [15:0] hb;
        phase_t      nph;
        logic [7:0]  opm;
        r = '0;
        case (it.mode)
            CMD_ENABLE:
            begin
                st = it.drive_status & SW_STATE_MASK;
                r.result_code = RC_BUSY;
                if (seq_phase == PH_ENABLED)
                    r.result_code = RC_OK;
                else
                begin
                    // Targets follow the drive until it reaches operation enabled.
                    if (st != SW_OP_ENABLED)
                    begin
                        r.target_position       = it.act_position;
                        r.target_position_write = 1'b1;
                        r.target_velocity_write = 1'b1;
                        r.target_torque_write   = 1'b1;
                    end
                    if (it.shown_mode != OPM_CST)
                    begin
                        r.op_mode_value = OPM_CST;
                        r.op_mode_write = 1'b1;
                    end
                    else if (st == SW_SWITCH_DIS_A || st == SW_SWITCH_DIS_B)
                    begin
                        r.ctrl_word       = CW_SHUTDOWN;
                        r.ctrl_word_write = 1'b1;
                    end
                    else if (st == SW_READY)
                    begin
                        r.ctrl_word       = CW_SWITCH_ON;
                        r.ctrl_word_write = 1'b1;
                    end
                    else if (st == SW_SWITCHED_ON)
                    begin
                        r.ctrl_word       = CW_ENABLE_OP;
                        r.ctrl_word_write = 1'b1;
                    end
                    else if (st == SW_OP_ENABLED)
                    begin
                        settle_ctr = settle_ctr + 8'd1;
                        if (settle_ctr >= cfg_settle)
                        begin
                            settle_ctr = '0;
                            seq_phase  = PH_ENABLED;
                        end
                    end
                    else
                    begin
                        // Any other power state gets a fault reset, up to the limit.
                        r.ctrl_word       = CW_FAULT_RESET;
                        r.ctrl_word_write = 1'b1;
                        if (fault_ctr >= cfg_retries)
                        begin
                            fault_ctr     = '0;
                            seq_phase     = PH_INIT;
                            r.result_code = RC_ENABLE_FAILED;
                        end
                        else
                            fault_ctr = fault_ctr + 16'd1;
                    end
                end
            end
            CMD_HOME:
            begin
                hb = it.drive_status & SW_HOME_MASK;
                if (seq_phase == PH_HOMED)
                    r.result_code = RC_OK;
                else if (seq_phase != PH_ENABLED)
                    r.result_code = RC_NOT_ENABLED;
                else if (it.shown_mode != OPM_HOMING)
                begin
                    r.op_mode_value = OPM_HOMING;
                    r.op_mode_write = 1'b1;
                    r.result_code   = RC_BUSY;
                end
                else if (hb == SW_HOME_IDLE)
                begin
                    // Start bit high below pulse length, low below twice it, then over.
                    if (home_ctr != HOME_COUNT_MAX)
                        home_ctr = home_ctr + 8'd1;
                    if (home_ctr < cfg_pulse)
                    begin
                        r.ctrl_word       = CW_HOME_START;
                        r.ctrl_word_write = 1'b1;
                    end
                    else if (int'(home_ctr) < 2 * int'(cfg_pulse))
                    begin
                        r.ctrl_word       = CW_ENABLE_OP;
                        r.ctrl_word_write = 1'b1;
                    end
                    else
                        home_ctr = '0;
                    r.result_code = RC_HOME_NOT_STARTED;
                end
                else
                begin
                    home_ctr      = '0;
                    r.result_code = RC_HOME_RUNNING;
                    if (hb == SW_HOME_ACTIVE)
                    begin
                        r.ctrl_word       = CW_HOME_START;
                        r.ctrl_word_write = 1'b1;
                    end
                    else if (hb == SW_HOME_ERR_A || hb == SW_HOME_ERR_B)
                    begin
                        r.ctrl_word       = CW_HALT;
                        r.ctrl_word_write = 1'b1;
                        r.result_code     = RC_HOME_ERROR;
                    end
                    else if (hb == SW_HOME_DONE)
                    begin
                        seq_phase     = PH_HOMED;
                        r.result_code = RC_OK;
                    end
                end
            end
            CMD_SET_CSP, CMD_SET_CSV, CMD_SET_CST:
            begin
                case (it.mode)
                    CMD_SET_CSP:
                    begin
                        nph = PH_CSP;
                        opm = OPM_CSP;
                    end
                    CMD_SET_CSV:
                    begin
                        nph = PH_CSV;
                        opm = OPM_CSV;
                    end
                    default:
                    begin
                        nph = PH_CST;
                        opm = OPM_CST;
                    end
                endcase
                r.result_code = RC_MODE_SET;
                if (seq_phase != nph)
                begin
                    // Entering a run mode seeds its target before the switch.
                    if (nph == PH_CSP)
                    begin
                        r.target_position       = it.act_position;
                        r.target_position_write = 1'b1;
                    end
                    else if (nph == PH_CSV)
                        r.target_velocity_write = 1'b1;
                    else
                        r.target_torque_write = 1'b1;
                    seq_phase = nph;
                    if (it.shown_mode != opm)
                    begin
                        r.op_mode_value = opm;
                        r.op_mode_write = 1'b1;
                        r.result_code   = RC_MODE_SETTING;
                    end
                end
            end
            CMD_SET_VEL:
            begin
                r.result_code = RC_WRONG_MODE;
                if (seq_phase == PH_CSV)
                begin
                    r.target_velocity       = it.velocity_value;
                    r.target_velocity_write = 1'b1;
                    r.result_code           = RC_OK;
                end
            end
            CMD_SET_TORQUE:
            begin
                r.result_code = RC_WRONG_MODE;
                if (seq_phase == PH_CST)
                begin
                    r.target_torque       = it.torque_value;
                    r.target_torque_write = 1'b1;
                    r.result_code         = RC_OK;
                end
            end
            default:
                r.result_code = RC_INVALID;
        endcase
        r.phase_now = seq_phase;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // Driver: a new word goes out once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.data  <= '0;
        end
        else if (!cmd_bus.valid || cmd_taken)
        begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                cmd_bus.data  <= cmd_queue.pop_front();
                cmd_bus.valid <= 1'b1;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
        rsp_bus.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Monitor: predicts on each accepted command, checks each accepted result.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        cmd_taken = cmd_bus.valid && cmd_bus.ready;
        if (rst_n)
        begin
            if (cmd_taken)
                expected_rsp.insert(expected_rsp.size(),
                                    sequencer_response(cmd_bus.data));
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with none expected: %h",
                                 $time, rsp_bus.data);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("ctrl_word", want.ctrl_word,
                                rsp_bus.data.ctrl_word);
                    check_field("ctrl_word_write", want.ctrl_word_write,
                                rsp_bus.data.ctrl_word_write);
                    check_field("op_mode_value", want.op_mode_value,
                                rsp_bus.data.op_mode_value);
                    check_field("op_mode_write", want.op_mode_write,
                                rsp_bus.data.op_mode_write);
                    check_field("target_position", want.target_position,
                                rsp_bus.data.target_position);
                    check_field("target_position_write", want.target_position_write,
                                rsp_bus.data.target_position_write);
                    check_field("target_velocity", want.target_velocity,
                                rsp_bus.data.target_velocity);
                    check_field("target_velocity_write", want.target_velocity_write,
                                rsp_bus.data.target_velocity_write);
                    check_field("target_torque", want.target_torque,
                                rsp_bus.data.target_torque);
                    check_field("target_torque_write", want.target_torque_write,
                                rsp_bus.data.target_torque_write);
                    check_field("result_code", want.result_code,
                                rsp_bus.data.result_code);
                    check_field("phase_now", want.phase_now, rsp_bus.data.phase_now);
                end
            end
        end
    end

    function automatic in_item_t make_cmd(cmd_t c, logic [15:0] sw, logic [7:0] md);
        in_item_t it;
        it.mode           = c;
        it.drive_status   = sw;
        it.shown_mode     = md;
        it.act_position   = $urandom;
        it.velocity_value = $urandom;
        it.torque_value   = 16'($urandom);
        return it;
    endfunction

    // Status words with a chosen power state or homing state, other bits random.
    function automatic logic [15:0] sw_with_state(logic [15:0] st);
        return (16'($urandom) & ~SW_STATE_MASK) | st;
    endfunction

    function automatic logic [15:0] sw_with_home(logic [15:0] hb);
        return (16'($urandom) & ~SW_HOME_MASK) | hb;
    endfunction

    task automatic queue_cmd(in_item_t it);
        cmd_queue.insert(cmd_queue.size(), it);
        n_queued++;
    endtask

    // Waits until every word has been sent and every result has come back.
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || cmd_bus.valid || expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SETTLE_CYCLES:     cfg_settle  = val[7:0];
            CFG_FAULT_RETRY_LIMIT: cfg_retries = val;
            default:               cfg_pulse   = val[6:0];
        endcase
    endtask

    task automatic set_config(logic [7:0] settle, logic [15:0] retries, logic [6:0] pulse);
        write_reg(CFG_SETTLE_CYCLES, {8'h00, settle});
        write_reg(CFG_FAULT_RETRY_LIMIT, retries);
        write_reg(CFG_HOME_PULSE_CYCLES, {9'h000, pulse});
    endtask

    // Walk through the power states up to operation enabled, with detours.
    task automatic gen_enable();
        int n;
        if ($urandom_range(0, 2) == 0)
            queue_cmd(make_cmd(CMD_ENABLE, 16'($urandom), 8'($urandom)));
        if ($urandom_range(0, 1) != 0)
            queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(($urandom_range(0, 1) != 0) ?
                               SW_SWITCH_DIS_A : SW_SWITCH_DIS_B), OPM_CST));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                queue_cmd(make_cmd(CMD_ENABLE, ($urandom_range(0, 1) != 0) ?
                                   sw_with_state(SW_FAULT) : 16'($urandom), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_READY), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_SWITCHED_ON), OPM_CST));
        n = ($urandom_range(0, 4) != 0) ? int'(cfg_settle) : $urandom_range(1, cfg_settle);
        repeat (n)
            queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_OP_ENABLED), OPM_CST));
        if ($urandom_range(0, 2) == 0)
            queue_cmd(make_cmd(CMD_ENABLE, 16'($urandom), 8'($urandom)));
    endtask

    // Homing, usually after an enable: start pulses, running and error states, done.
    task automatic gen_homing();
        logic [15:0] hb;
        int          n;
        if ($urandom_range(0, 3) != 0)
            gen_enable();
        if ($urandom_range(0, 2) == 0)
            queue_cmd(make_cmd(CMD_HOME, 16'($urandom), 8'($urandom)));
        n = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2 * int'(cfg_pulse) + 2) :
                                          $urandom_range(0, 4);
        repeat (n)
            queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_IDLE), OPM_HOMING));
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 3))
                0:       hb = SW_HOME_ACTIVE;
                1:       hb = SW_HOME_ERR_A;
                2:       hb = SW_HOME_ERR_B;
                default: hb = 16'($urandom) & SW_HOME_MASK;
            endcase
            queue_cmd(make_cmd(CMD_HOME, sw_with_home(hb), OPM_HOMING));
        end
        if ($urandom_range(0, 4) != 0)
            queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_DONE), OPM_HOMING));
        if ($urandom_range(0, 2) == 0)
            queue_cmd(make_cmd(CMD_HOME, 16'($urandom), OPM_HOMING));
    endtask

    // Run mode switches followed by target setters.
    task automatic gen_modes();
        cmd_t       c;
        logic [7:0] opm;
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    c   = CMD_SET_CSP;
                    opm = OPM_CSP;
                end
                1:
                begin
                    c   = CMD_SET_CSV;
                    opm = OPM_CSV;
                end
                default:
                begin
                    c   = CMD_SET_CST;
                    opm = OPM_CST;
                end
            endcase
            queue_cmd(make_cmd(c, 16'($urandom),
                               ($urandom_range(0, 1) != 0) ? opm : 8'($urandom)));
            repeat ($urandom_range(0, 4))
                queue_cmd(make_cmd(($urandom_range(0, 1) != 0) ? CMD_SET_VEL : CMD_SET_TORQUE,
                                   16'($urandom), 8'($urandom)));
        end
    endtask

    // Fully random words, the unused command code among them.
    task automatic gen_noise();
        in_item_t it;
        repeat ($urandom_range(1, 4))
        begin
            it      = make_cmd(CMD_ENABLE, 16'($urandom), 8'($urandom));
            it.mode = 3'($urandom);
            queue_cmd(it);
        end
    endtask

    task automatic gen_random(int count);
        int first;
        first = n_queued;
        while (n_queued - first < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gen_enable();
                3, 4, 5: gen_homing();
                6, 7, 8: gen_modes();
                default: gen_noise();
            endcase
        end
        // Long settle and pulse walks can overshoot; cut the tail back.
        while (n_queued - first > count && cmd_queue.size() != 0)
        begin
            void'(cmd_queue.pop_back());
            n_queued--;
        end
    endtask

    // Stimulus: directed walk, then random phases under several settings.
    initial
    begin : stimulus
        in_item_t it;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SETTLE_CYCLES;
        cfg_wdata     = '0;
        tx_idle_pct   = 29;
        rx_idle_pct   = 85;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        set_config(8'd2, 16'd1, 7'd2);

        // Rejected command, a setter and homing before any enable.
        it      = make_cmd(CMD_ENABLE, 16'($urandom), 8'($urandom));
        it.mode = CMD_UNUSED;
        queue_cmd(it);
        it = make_cmd(CMD_SET_TORQUE, 16'($urandom), 8'($urandom));
        it.torque_value = 16'sh8000;
        queue_cmd(it);
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_DONE), OPM_HOMING));

        // Enable: wrong mode shown, switch disabled, fault retries exhausted.
        it = make_cmd(CMD_ENABLE, sw_with_state(SW_SWITCH_DIS_A), 8'h80);
        it.act_position = 32'sh8000_0000;
        queue_cmd(it);
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_SWITCH_DIS_A), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_SWITCH_DIS_B), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, 16'h0000, OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, 16'hffff, OPM_CST));

        // Enable: ready, switched on, settle in operation enabled, then enabled.
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_READY), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_SWITCHED_ON), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_OP_ENABLED), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, sw_with_state(SW_OP_ENABLED), OPM_CST));
        queue_cmd(make_cmd(CMD_ENABLE, 16'($urandom), 8'($urandom)));
        it = make_cmd(CMD_SET_VEL, 16'($urandom), 8'($urandom));
        it.velocity_value = 32'sh7fff_ffff;
        queue_cmd(it);

        // Homing: mode write, start pulse and its end, running, errors, done.
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_IDLE), 8'h7f));
        repeat (4)
            queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_IDLE), OPM_HOMING));
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_ACTIVE), OPM_HOMING));
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_ERR_A), OPM_HOMING));
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_ERR_B), OPM_HOMING));
        queue_cmd(make_cmd(CMD_HOME, sw_with_home(SW_HOME_DONE), OPM_HOMING));

        // Run modes with and without the mode already shown, and their setters.
        it = make_cmd(CMD_SET_CSP, 16'($urandom), OPM_CSP);
        it.act_position = 32'sh7fff_ffff;
        queue_cmd(it);
        queue_cmd(make_cmd(CMD_SET_CSV, 16'($urandom), 8'h00));
        it = make_cmd(CMD_SET_VEL, 16'($urandom), 8'($urandom));
        it.velocity_value = 32'sh8000_0000;
        queue_cmd(it);
        queue_cmd(make_cmd(CMD_SET_CST, 16'($urandom), OPM_CST));
        it = make_cmd(CMD_SET_TORQUE, 16'($urandom), 8'($urandom));
        it.torque_value = 16'sh7fff;
        queue_cmd(it);
        wait_idle();

        // Slow receiver: short settle and pulse, then the lowest settings.
        set_config(8'd3, 16'd2, 7'd3);
        gen_random(260);
        wait_idle();
        set_config(8'd1, 16'd1, 7'd1);
        gen_random(260);
        wait_idle();

        // Slow sender: the highest settings.
        tx_idle_pct = 85;
        rx_idle_pct = 29;
        set_config(8'd255, 16'd65535, 7'd127);
        gen_random(300);
        wait_idle();

        // No idling: the reset defaults written back.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(SETTLE_CYCLES_RST, FAULT_RETRY_LIMIT_RST, HOME_PULSE_CYCLES_RST);
        gen_random(230);
        wait_idle();

        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
